@@ design/aabb_axis_collision_resolver_core_defines.svh @@
// assertion macros for the aabb collision resolver
// no dependencies; included by the core, the one file that carries assertions
`ifndef AABB_AXIS_COLLISION_RESOLVER_CORE_DEFINES_SVH
`define AABB_AXIS_COLLISION_RESOLVER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define AACR_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define AACR_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/aacr_pkg.sv @@
// shared types, constants and helpers of the aabb collision resolver
// no dependencies
package aacr_pkg;

	localparam int MAX_BLOCKS = 1024;
	localparam int AW = $clog2(MAX_BLOCKS);
	localparam int CW = $clog2(MAX_BLOCKS + 1);
	localparam int PW = 36;
	localparam int CRDW = 32;
	localparam logic signed [PW-1:0] HALF_BLOCK = 36'sd32768;
	localparam logic [5:0] SMALL_LIMIT = 6'd43;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_ADD = 2'd1;
	localparam logic [1:0] OP_MOVE = 2'd2;
	localparam logic [1:0] OP_NONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_STILL = 2'd2;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_HALF_W = 2'd1;
	localparam logic [1:0] REG_HALF_H = 2'd2;
	localparam logic [1:0] REG_SKIN = 2'd3;

	localparam logic [1:0] PASS_X = 2'd0;
	localparam logic [1:0] PASS_Y = 2'd1;
	localparam logic [1:0] PASS_Z = 2'd2;
	localparam logic [1:0] PASS_SWEEP = 2'd3;

	typedef logic signed [PW-1:0] pos_t;
	typedef logic signed [CRDW-1:0] crd_t;

	typedef struct packed {
		pos_t x;
		pos_t y;
		pos_t z;
	} vec_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SETUP = 5'b00010,
		S_PASS  = 5'b00100,
		S_FIN   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	function automatic crd_t sat32(input pos_t v);
		pos_t hi;
		pos_t lo;
		hi = pos_t'(32'sh7fffffff);
		lo = -pos_t'(36'sh080000000);
		if (v > hi) begin
			return crd_t'(32'sh7fffffff);
		end else if (v < lo) begin
			return crd_t'(32'sh80000000);
		end
		return v[CRDW-1:0];
	endfunction

endpackage

@@ design/aacr_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module aacr_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ design/aacr_hit_unit.sv @@
// shared overlap compare unit: body box against one unit block, per axis
// depends on aacr_pkg
module aacr_hit_unit (
	input  aacr_pkg::vec_t pos,
	input  aacr_pkg::pos_t half_w,
	input  aacr_pkg::pos_t half_h,
	input  aacr_pkg::vec_t ctr,
	input  logic           inclusive,
	output logic [2:0]     overlap
);

	aacr_pkg::pos_t lo_body [3];
	aacr_pkg::pos_t hi_body [3];
	aacr_pkg::pos_t lo_blk [3];
	aacr_pkg::pos_t hi_blk [3];

	always_comb begin
		lo_body[0] = pos.x - half_w;
		hi_body[0] = pos.x + half_w;
		lo_body[1] = pos.y - half_h;
		hi_body[1] = pos.y + half_h;
		lo_body[2] = pos.z - half_w;
		hi_body[2] = pos.z + half_w;
		lo_blk[0] = ctr.x - aacr_pkg::HALF_BLOCK;
		hi_blk[0] = ctr.x + aacr_pkg::HALF_BLOCK;
		lo_blk[1] = ctr.y - aacr_pkg::HALF_BLOCK;
		hi_blk[1] = ctr.y + aacr_pkg::HALF_BLOCK;
		lo_blk[2] = ctr.z - aacr_pkg::HALF_BLOCK;
		hi_blk[2] = ctr.z + aacr_pkg::HALF_BLOCK;
		for (int a = 0; a < 3; a++) begin
			if (inclusive) begin
				overlap[a] = (hi_body[a] >= lo_blk[a]) && (lo_body[a] <= hi_blk[a]);
			end else begin
				overlap[a] = (lo_body[a] < hi_blk[a]) && (hi_body[a] > lo_blk[a]);
			end
		end
	end

endmodule

@@ design/aabb_axis_collision_resolver_core.sv @@
// aabb collision resolver: block store, move sequencer, output register, apb registers
// depends on aacr_pkg, aacr_ram, aacr_hit_unit and the defines header
// sequence: clear, add and pass-through moves go from idle to the output state and then to the output
// register; a resolved move runs four passes, each of a setup state, one read per stored block and a
// tail (a pass whose axis does not move: setup only), then the final state and the output state
// throughput: one transaction at a time, input ready again once the result is registered;
// reset: arst_n clears registers to defaults, block count and ground flag to zero
`include "aabb_axis_collision_resolver_core_defines.svh"
module aabb_axis_collision_resolver_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [191:0] s_axis_tdata,  // first_x, first_y, first_z, desired_x, desired_y, desired_z
	input  logic [1:0]   s_axis_tuser,  // op
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [103:0] m_axis_tdata,  // resolved_x, resolved_y, resolved_z, on_ground, zero pad
	output logic [1:0]   m_axis_tuser,  // status
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [3:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic        en_q;
	logic [18:0] hw_q;
	logic [18:0] hh_q;
	logic [15:0] skin_q;
	logic        cfg_wr;

	aacr_pkg::state_t state_q;
	logic [aacr_pkg::CW-1:0] cnt_q;
	logic [aacr_pkg::CW-1:0] rd_cnt_q;
	logic [1:0]  pass_q;
	logic        vld_s1;
	logic        gflag_q;
	aacr_pkg::vec_t prev_q;
	aacr_pkg::vec_t want_q;
	aacr_pkg::vec_t vel_q;
	aacr_pkg::vec_t p_q;
	logic        found_q;
	aacr_pkg::pos_t best_q;

	aacr_pkg::crd_t res_x_q;
	aacr_pkg::crd_t res_y_q;
	aacr_pkg::crd_t res_z_q;
	logic        res_g_q;
	logic [1:0]  res_st_q;
	logic        m_valid_q;
	logic [103:0] m_data_q;
	logic [1:0]  m_user_q;

	logic        accept;
	aacr_pkg::vec_t in_prev;
	aacr_pkg::vec_t in_want;
	aacr_pkg::vec_t in_vel;
	logic        still;
	logic [3:0]  av [3];
	logic [6:0]  sq_full;
	logic [5:0]  sq_sum;

	logic        ram_we;
	logic        ram_re;
	logic [aacr_pkg::AW-1:0] ram_raddr;
	logic [95:0] ram_rdata;
	aacr_pkg::vec_t ctr;
	logic [2:0]  overlap;
	aacr_pkg::pos_t hw_p;
	aacr_pkg::pos_t hh_p;
	aacr_pkg::pos_t skin_p;

	aacr_pkg::pos_t ax_vel;
	aacr_pkg::pos_t ax_c;
	aacr_pkg::pos_t ax_he;
	aacr_pkg::pos_t clamp;
	aacr_pkg::pos_t top;
	aacr_pkg::pos_t before_y;
	aacr_pkg::pos_t after_y;
	logic        land;
	logic        pass_on;
	logic        pass_done;
	aacr_pkg::pos_t fin_y;
	logic        fin_g;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b1;
			hw_q <= 19'd16384;
			hh_q <= 19'd65536;
			skin_q <= 16'd66;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				aacr_pkg::REG_ENABLE: en_q <= pwdata[0];
				aacr_pkg::REG_HALF_W: hw_q <= pwdata[18:0];
				aacr_pkg::REG_HALF_H: hh_q <= pwdata[18:0];
				aacr_pkg::REG_SKIN:   skin_q <= pwdata[15:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			aacr_pkg::REG_ENABLE: prdata = {31'd0, en_q};
			aacr_pkg::REG_HALF_W: prdata = {13'd0, hw_q};
			aacr_pkg::REG_HALF_H: prdata = {13'd0, hh_q};
			aacr_pkg::REG_SKIN:   prdata = {16'd0, skin_q};
		endcase
	end

	assign hw_p = aacr_pkg::pos_t'(hw_q);
	assign hh_p = aacr_pkg::pos_t'(hh_q);
	assign skin_p = aacr_pkg::pos_t'(skin_q);

	// input decode and no-motion test
	assign s_axis_tready = (state_q == aacr_pkg::S_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;

	always_comb begin
		in_prev.x = aacr_pkg::pos_t'(signed'(s_axis_tdata[31:0]));
		in_prev.y = aacr_pkg::pos_t'(signed'(s_axis_tdata[63:32]));
		in_prev.z = aacr_pkg::pos_t'(signed'(s_axis_tdata[95:64]));
		in_want.x = aacr_pkg::pos_t'(signed'(s_axis_tdata[127:96]));
		in_want.y = aacr_pkg::pos_t'(signed'(s_axis_tdata[159:128]));
		in_want.z = aacr_pkg::pos_t'(signed'(s_axis_tdata[191:160]));
		in_vel.x = in_want.x - in_prev.x;
		in_vel.y = in_want.y - in_prev.y;
		in_vel.z = in_want.z - in_prev.z;
	end

	// magnitudes of small velocities, valid only when all three magnitudes are at most 7
	always_comb begin
		av[0] = in_vel.x[aacr_pkg::PW-1] ? 4'(-in_vel.x[3:0]) : in_vel.x[3:0];
		av[1] = in_vel.y[aacr_pkg::PW-1] ? 4'(-in_vel.y[3:0]) : in_vel.y[3:0];
		av[2] = in_vel.z[aacr_pkg::PW-1] ? 4'(-in_vel.z[3:0]) : in_vel.z[3:0];
		sq_full = 7'(av[0][2:0]) * 7'(av[0][2:0]) + 7'(av[1][2:0]) * 7'(av[1][2:0])
			+ 7'(av[2][2:0]) * 7'(av[2][2:0]);
		sq_sum = (sq_full > 7'd63) ? 6'd63 : sq_full[5:0];
		still = (in_vel.x > -aacr_pkg::pos_t'(7)) && (in_vel.x < aacr_pkg::pos_t'(7))
			&& (in_vel.y > -aacr_pkg::pos_t'(7)) && (in_vel.y < aacr_pkg::pos_t'(7))
			&& (in_vel.z > -aacr_pkg::pos_t'(7)) && (in_vel.z < aacr_pkg::pos_t'(7))
			&& (sq_sum < aacr_pkg::SMALL_LIMIT);
	end

	// block store
	assign ram_we = accept && (s_axis_tuser == aacr_pkg::OP_ADD)
		&& (cnt_q < aacr_pkg::CW'(aacr_pkg::MAX_BLOCKS));
	assign ram_re = (state_q == aacr_pkg::S_PASS) && (rd_cnt_q < cnt_q);
	assign ram_raddr = rd_cnt_q[aacr_pkg::AW-1:0];

	aacr_ram #(
		.WIDTH(96),
		.DEPTH(aacr_pkg::MAX_BLOCKS)
	) u_store (
		.clk(clk),
		.we(ram_we),
		.waddr(cnt_q[aacr_pkg::AW-1:0]),
		.wdata(s_axis_tdata[95:0]),
		.re(ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign ctr.x = aacr_pkg::pos_t'(signed'(ram_rdata[31:0]));
	assign ctr.y = aacr_pkg::pos_t'(signed'(ram_rdata[63:32]));
	assign ctr.z = aacr_pkg::pos_t'(signed'(ram_rdata[95:64]));

	aacr_hit_unit u_hit (
		.pos(p_q),
		.half_w(hw_p),
		.half_h(hh_p),
		.ctr(ctr),
		.inclusive(pass_q == aacr_pkg::PASS_SWEEP),
		.overlap(overlap)
	);

	// per-axis selection for the current pass
	always_comb begin
		unique case (pass_q)
			aacr_pkg::PASS_X: begin
				ax_vel = vel_q.x; ax_c = ctr.x; ax_he = hw_p;
				pass_on = (vel_q.x != '0);
			end
			aacr_pkg::PASS_Y: begin
				ax_vel = vel_q.y; ax_c = ctr.y; ax_he = hh_p;
				pass_on = (vel_q.y != '0);
			end
			aacr_pkg::PASS_Z: begin
				ax_vel = vel_q.z; ax_c = ctr.z; ax_he = hw_p;
				pass_on = (vel_q.z != '0);
			end
			aacr_pkg::PASS_SWEEP: begin
				ax_vel = vel_q.y; ax_c = ctr.y; ax_he = hh_p;
				pass_on = vel_q.y[aacr_pkg::PW-1];
			end
		endcase
		if (ax_vel[aacr_pkg::PW-1]) begin
			clamp = ax_c + (aacr_pkg::HALF_BLOCK + ax_he + skin_p);
		end else begin
			clamp = ax_c - (aacr_pkg::HALF_BLOCK + ax_he + skin_p);
		end
		top = ctr.y + aacr_pkg::HALF_BLOCK;
		before_y = prev_q.y - hh_p;
		after_y = p_q.y - hh_p;
		land = overlap[0] && overlap[2] && (before_y >= top - skin_p)
			&& (after_y <= top + skin_p);
		pass_done = (rd_cnt_q == cnt_q) && !vld_s1;
		fin_y = found_q ? best_q + hh_p + skin_p : p_q.y;
		fin_g = vel_q.y[aacr_pkg::PW-1] && (found_q || (fin_y - want_q.y > skin_p));
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aacr_pkg::S_IDLE;
			cnt_q <= '0;
			rd_cnt_q <= '0;
			pass_q <= aacr_pkg::PASS_X;
			vld_s1 <= 1'b0;
			gflag_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			unique case (state_q)
				aacr_pkg::S_IDLE: begin
					if (accept) begin
						state_q <= aacr_pkg::S_OUT;
						unique case (s_axis_tuser)
							aacr_pkg::OP_CLEAR: cnt_q <= '0;
							aacr_pkg::OP_ADD: begin
								if (ram_we) begin
									cnt_q <= cnt_q + 1'b1;
								end
							end
							aacr_pkg::OP_MOVE: begin
								if (en_q && !still) begin
									state_q <= aacr_pkg::S_SETUP;
									pass_q <= aacr_pkg::PASS_X;
									found_q <= 1'b0;
								end
							end
							aacr_pkg::OP_NONE: ;
						endcase
					end
				end
				aacr_pkg::S_SETUP: begin
					rd_cnt_q <= '0;
					vld_s1 <= 1'b0;
					if (pass_on) begin
						state_q <= aacr_pkg::S_PASS;
					end else if (pass_q == aacr_pkg::PASS_SWEEP) begin
						state_q <= aacr_pkg::S_FIN;
					end else begin
						pass_q <= pass_q + 1'b1;
					end
				end
				aacr_pkg::S_PASS: begin
					vld_s1 <= ram_re;
					if (ram_re) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					if (vld_s1 && (pass_q == aacr_pkg::PASS_SWEEP) && land) begin
						found_q <= 1'b1;
					end
					if (pass_done) begin
						if (pass_q == aacr_pkg::PASS_SWEEP) begin
							state_q <= aacr_pkg::S_FIN;
						end else begin
							pass_q <= pass_q + 1'b1;
							state_q <= aacr_pkg::S_SETUP;
						end
					end
				end
				aacr_pkg::S_FIN: begin
					gflag_q <= fin_g;
					state_q <= aacr_pkg::S_OUT;
				end
				aacr_pkg::S_OUT: begin
					if (!m_valid_q || m_axis_tready) begin
						state_q <= aacr_pkg::S_IDLE;
					end
				end
				default: state_q <= aacr_pkg::S_IDLE;
			endcase
		end
	end

	// move datapath and pending result
	always_ff @(posedge clk) begin
		unique case (state_q)
			aacr_pkg::S_IDLE: begin
				prev_q <= in_prev;
				want_q <= in_want;
				vel_q <= in_vel;
				p_q <= in_prev;
				res_x_q <= '0;
				res_y_q <= '0;
				res_z_q <= '0;
				res_g_q <= 1'b0;
				res_st_q <= aacr_pkg::ST_OK;
				if (s_axis_tuser == aacr_pkg::OP_ADD && !ram_we) begin
					res_st_q <= aacr_pkg::ST_FULL;
				end
				if (s_axis_tuser == aacr_pkg::OP_MOVE && (!en_q || still)) begin
					res_x_q <= aacr_pkg::sat32(in_want.x);
					res_y_q <= aacr_pkg::sat32(in_want.y);
					res_z_q <= aacr_pkg::sat32(in_want.z);
					res_g_q <= gflag_q;
					res_st_q <= (en_q && still) ? aacr_pkg::ST_STILL : aacr_pkg::ST_OK;
				end
			end
			aacr_pkg::S_SETUP: begin
				best_q <= '0;
				if (pass_on) begin
					unique case (pass_q)
						aacr_pkg::PASS_X: p_q.x <= p_q.x + vel_q.x;
						aacr_pkg::PASS_Y: p_q.y <= p_q.y + vel_q.y;
						aacr_pkg::PASS_Z: p_q.z <= p_q.z + vel_q.z;
						aacr_pkg::PASS_SWEEP: ;
					endcase
				end
			end
			aacr_pkg::S_PASS: begin
				if (vld_s1) begin
					if (pass_q == aacr_pkg::PASS_SWEEP) begin
						if (land && (!found_q || top > best_q)) begin
							best_q <= top;
						end
					end else if (&overlap) begin
						unique case (pass_q)
							aacr_pkg::PASS_X: p_q.x <= clamp;
							aacr_pkg::PASS_Y: p_q.y <= clamp;
							aacr_pkg::PASS_Z: p_q.z <= clamp;
							aacr_pkg::PASS_SWEEP: ;
						endcase
					end
				end
			end
			aacr_pkg::S_FIN: begin
				res_x_q <= aacr_pkg::sat32(p_q.x);
				res_y_q <= aacr_pkg::sat32(fin_y);
				res_z_q <= aacr_pkg::sat32(p_q.z);
				res_g_q <= fin_g;
				res_st_q <= aacr_pkg::ST_OK;
			end
			aacr_pkg::S_OUT: ;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == aacr_pkg::S_OUT && (!m_valid_q || m_axis_tready)) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aacr_pkg::S_OUT && (!m_valid_q || m_axis_tready)) begin
			m_data_q <= {7'd0, res_g_q, res_z_q, res_y_q, res_x_q};
			m_user_q <= res_st_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = m_data_q;
	assign m_axis_tuser = m_user_q;

	`AACR_ASSERT_IMP(a_ready_no_read, clk, arst_n, s_axis_tready, !vld_s1 && !ram_re, "read while ready")
	`AACR_ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, cnt_q <= aacr_pkg::CW'(aacr_pkg::MAX_BLOCKS), "count over max")
	`AACR_ASSERT_IMP(a_write_on_accept, clk, arst_n, ram_we, accept, "store write without transaction")
	`AACR_ASSERT_NXT(a_out_load, clk, arst_n, state_q == aacr_pkg::S_OUT && !m_valid_q, m_valid_q, "result not loaded")

endmodule

@@ test/tb_aabb_axis_collision_resolver_core.sv @@
// testbench for aabb_axis_collision_resolver_core: directed table and random phases
// checks each result against an in-bench collision predictor or a typed table result; depends on aacr_pkg and the rtl
module tb_aabb_axis_collision_resolver_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int UNIT = 65536;
	localparam int HALF = 32768;
	localparam int STALL_LIMIT = 20000;

	typedef struct {
		logic [1:0] op;
		int fx, fy, fz, dx, dy, dz;
	} motion_req_t;

	typedef struct {
		int rx, ry, rz;
		bit grounded;
		logic [1:0] status;
	} motion_res_t;

	typedef struct {
		motion_req_t req;
		bit typed;
		motion_res_t res;
	} table_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [191:0] s_axis_tdata;   // first_x, first_y, first_z, desired_x, desired_y, desired_z
	logic [1:0]   s_axis_tuser;   // op
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;   // resolved_x, resolved_y, resolved_z, on_ground, zero pad
	logic [1:0]   m_axis_tuser;   // status
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [3:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	aabb_axis_collision_resolver_core DUT (.*);

	// predictor state
	bit          cfg_enable;
	logic [18:0] cfg_half_w;
	logic [18:0] cfg_half_h;
	logic [15:0] cfg_skin;
	int          store_x [aacr_pkg::MAX_BLOCKS];
	int          store_y [aacr_pkg::MAX_BLOCKS];
	int          store_z [aacr_pkg::MAX_BLOCKS];
	int          store_count;
	bit          last_ground;
	longint      body [3];
	longint      extent [3];

	motion_res_t pending_results [$];
	int          error_count;
	int          quiet_cycles;
	bit          typed_now;
	motion_res_t typed_res;
	bit          no_gaps;
	int          out_hold;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint block_axis(int i, int a);
		if (a == 0) return store_x[i];
		if (a == 1) return store_y[i];
		return store_z[i];
	endfunction

	function automatic bit body_overlaps(int i);
		longint c;
		for (int a = 0; a < 3; a++) begin
			c = block_axis(i, a);
			if (!(body[a] - extent[a] < c + HALF && body[a] + extent[a] > c - HALF))
				return 0;
		end
		return 1;
	endfunction

	function automatic void clamp_axis(int a, longint vel);
		if (vel == 0) return;
		body[a] += vel;
		for (int i = 0; i < store_count; i++) begin
			if (!body_overlaps(i)) continue;
			if (vel > 0) body[a] = block_axis(i, a) - HALF - extent[a] - cfg_skin;
			else body[a] = block_axis(i, a) + HALF + extent[a] + cfg_skin;
		end
	endfunction

	function automatic int clip32(longint v);
		if (v > 64'sd2147483647) return 32'sh7fffffff;
		if (v < -64'sd2147483648) return 32'sh80000000;
		return int'(v);
	endfunction

	function automatic longint mag(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic motion_res_t resolve_move(motion_req_t q);
		motion_res_t r;
		longint start [3];
		longint goal [3];
		longint vel [3];
		longint skin, best, from_y, to_y, top, cx, cz;
		bit found, ground;
		r = '{0, 0, 0, 0, aacr_pkg::ST_OK};
		start = '{q.fx, q.fy, q.fz};
		goal = '{q.dx, q.dy, q.dz};
		for (int a = 0; a < 3; a++) vel[a] = goal[a] - start[a];
		skin = cfg_skin;
		ground = 0;
		case (q.op)
			aacr_pkg::OP_CLEAR: begin
				store_count = 0;
				return r;
			end
			aacr_pkg::OP_ADD: begin
				if (store_count >= aacr_pkg::MAX_BLOCKS) begin
					r.status = aacr_pkg::ST_FULL;
				end else begin
					store_x[store_count] = q.fx;
					store_y[store_count] = q.fy;
					store_z[store_count] = q.fz;
					store_count++;
				end
				return r;
			end
			aacr_pkg::OP_NONE: return r;
			default: ;
		endcase
		if (!cfg_enable || (mag(vel[0]) < 7 && mag(vel[1]) < 7 && mag(vel[2]) < 7 &&
				vel[0] * vel[0] + vel[1] * vel[1] + vel[2] * vel[2] < aacr_pkg::SMALL_LIMIT)) begin
			r.rx = q.dx;
			r.ry = q.dy;
			r.rz = q.dz;
			r.grounded = last_ground;
			r.status = cfg_enable ? aacr_pkg::ST_STILL : aacr_pkg::ST_OK;
			return r;
		end
		extent = '{cfg_half_w, cfg_half_h, cfg_half_w};
		body = start;
		for (int a = 0; a < 3; a++) clamp_axis(a, vel[a]);
		if (vel[1] < 0) begin
			found = 0;
			best = 0;
			from_y = start[1] - extent[1];
			to_y = body[1] - extent[1];
			for (int i = 0; i < store_count; i++) begin
				cx = store_x[i];
				cz = store_z[i];
				top = longint'(store_y[i]) + HALF;
				if (body[0] + extent[0] < cx - HALF || body[0] - extent[0] > cx + HALF) continue;
				if (body[2] + extent[2] < cz - HALF || body[2] - extent[2] > cz + HALF) continue;
				if (from_y >= top - skin && to_y <= top + skin) begin
					if (!found || top > best) best = top;
					found = 1;
				end
			end
			if (found) begin
				body[1] = best + extent[1] + skin;
				ground = 1;
			end
			if (body[1] - goal[1] > skin) ground = 1;
		end
		last_ground = ground;
		r.rx = clip32(body[0]);
		r.ry = clip32(body[1]);
		r.rz = clip32(body[2]);
		r.grounded = ground;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// input side: predict on every accepted transaction
	always @(posedge clk) begin
		motion_req_t q;
		motion_res_t r;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			q.op = s_axis_tuser;
			q.fx = s_axis_tdata[31:0];
			q.fy = s_axis_tdata[63:32];
			q.fz = s_axis_tdata[95:64];
			q.dx = s_axis_tdata[127:96];
			q.dy = s_axis_tdata[159:128];
			q.dz = s_axis_tdata[191:160];
			r = resolve_move(q);
			if (typed_now) r = typed_res;
			pending_results = {pending_results, r};
		end
	end

	// output side: compare and draw the next stall
	always @(posedge clk or negedge arst_n) begin
		motion_res_t e;
		int h;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_hold <= 0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected transaction", 1, 0);
			end else begin
				e = pending_results.pop_front();
				if (int'(m_axis_tdata[31:0]) != e.rx)
					report_mismatch("resolved_x", int'(m_axis_tdata[31:0]), e.rx);
				if (int'(m_axis_tdata[63:32]) != e.ry)
					report_mismatch("resolved_y", int'(m_axis_tdata[63:32]), e.ry);
				if (int'(m_axis_tdata[95:64]) != e.rz)
					report_mismatch("resolved_z", int'(m_axis_tdata[95:64]), e.rz);
				if (m_axis_tdata[96] != e.grounded)
					report_mismatch("on_ground", m_axis_tdata[96], e.grounded);
				if (m_axis_tuser != e.status)
					report_mismatch("status", m_axis_tuser, e.status);
			end
			h = no_gaps ? 0 : $urandom_range(0, 8);
			out_hold <= h;
			m_axis_tready <= (h == 0);
		end else if (out_hold != 0) begin
			out_hold <= out_hold - 1;
			m_axis_tready <= (out_hold == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("aabb_axis_collision_resolver_core verification failed");
			$finish;
		end
	end

	task automatic send(motion_req_t q, bit typed = 0,
			motion_res_t r = '{0, 0, 0, 0, aacr_pkg::ST_OK});
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= q.op;
		s_axis_tdata <= {q.dz, q.dy, q.dx, q.fz, q.fy, q.fx};
		typed_now <= typed;
		typed_res <= r;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		logic [31:0] mask;
		@(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		case (idx)
			aacr_pkg::REG_ENABLE: begin cfg_enable = val[0]; mask = 32'h1; end
			aacr_pkg::REG_HALF_W: begin cfg_half_w = val[18:0]; mask = 32'h7ffff; end
			aacr_pkg::REG_HALF_H: begin cfg_half_h = val[18:0]; mask = 32'h7ffff; end
			default: begin cfg_skin = val[15:0]; mask = 32'hffff; end
		endcase
		// read back
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata != (val & mask)) report_mismatch("register readback", prdata, val & mask);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(bit en, int hw, int hh, int skin);
		write_reg(aacr_pkg::REG_ENABLE, en);
		write_reg(aacr_pkg::REG_HALF_W, hw);
		write_reg(aacr_pkg::REG_HALF_H, hh);
		write_reg(aacr_pkg::REG_SKIN, skin);
	endtask

	function automatic int near_coord();
		return ($urandom_range(0, 12) - 6) * HALF
			+ ($urandom_range(0, 1) ? 0 : $urandom_range(0, 4095) - 2048);
	endfunction

	function automatic int step_delta();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 12) - 6;
			1: return 0;
			default: return $urandom_range(0, 3 * HALF) - 3 * HALF / 2;
		endcase
	endfunction

	function automatic motion_req_t random_item();
		motion_req_t q;
		int pick;
		pick = $urandom_range(0, 99);
		q = '{aacr_pkg::OP_MOVE, near_coord(), near_coord(), near_coord(), 0, 0, 0};
		if (pick < 3) begin
			q.op = aacr_pkg::OP_CLEAR;
		end else if (pick < 33) begin
			q.op = aacr_pkg::OP_ADD;
			q.fx = ($urandom_range(0, 6) - 3) * UNIT;
			q.fy = ($urandom_range(0, 6) - 3) * UNIT;
			q.fz = ($urandom_range(0, 6) - 3) * UNIT;
		end else if (pick < 35) begin
			q.op = aacr_pkg::OP_NONE;
		end else if (pick < 45) begin
			q = '{2'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		end
		q.dx = q.fx + step_delta();
		q.dy = q.fy + (($urandom_range(0, 2) == 0) ? -$urandom_range(0, 2 * UNIT) : step_delta());
		q.dz = q.fz + step_delta();
		if (pick >= 35 && pick < 45) begin
			q.dx = $urandom;
			q.dy = $urandom;
			q.dz = $urandom;
		end
		return q;
	endfunction

	table_row_t directed [] = '{
		'{'{aacr_pkg::OP_CLEAR, -1, -1, -1, -1, -1, -1}, 1, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_NONE, -1, -1, -1, -1, -1, -1}, 1, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_ADD, 0, 0, 0, -1, -1, -1}, 1, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_ADD, UNIT, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_ADD, 0, 0, UNIT, 0, 0, 0}, 1, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		// fall onto the block at the origin
		'{'{aacr_pkg::OP_MOVE, 0, 2 * UNIT, 0, 0, HALF, 0}, 0,
			'{0, 0, 0, 0, aacr_pkg::ST_OK}},
		// tiny motions right at the still threshold
		'{'{aacr_pkg::OP_MOVE, 5 * UNIT, 5 * UNIT, 5 * UNIT,
			5 * UNIT + 6, 5 * UNIT, 5 * UNIT}, 0, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_MOVE, 5 * UNIT, 5 * UNIT, 5 * UNIT,
			5 * UNIT + 4, 5 * UNIT + 4, 5 * UNIT + 3}, 0, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_MOVE, 5 * UNIT, 5 * UNIT, 5 * UNIT,
			5 * UNIT + 4, 5 * UNIT + 4, 5 * UNIT + 4}, 0, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_MOVE, 5 * UNIT, 5 * UNIT, 5 * UNIT,
			5 * UNIT - 7, 5 * UNIT, 5 * UNIT}, 0, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		// sideways pushes into the stored blocks and a downward move
		'{'{aacr_pkg::OP_MOVE, -2 * UNIT, 0, 0, 2 * UNIT, 0, 0}, 0,
			'{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_MOVE, 3 * UNIT, 0, 0, -UNIT, 0, 0}, 0,
			'{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_MOVE, 0, 0, -2 * UNIT, 0, 0, 2 * UNIT}, 0,
			'{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_MOVE, 0, 0, 0, 0, -UNIT, 0}, 0, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		// coordinate extremes, saturating outputs
		'{'{aacr_pkg::OP_MOVE, 32'sh80000000, 32'sh80000000, 32'sh80000000,
			32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 0, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_MOVE, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			32'sh80000000, 32'sh80000000, 32'sh80000000}, 0, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_ADD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0}, 1,
			'{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_ADD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0}, 1,
			'{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_MOVE, 32'sh7fff0000, 32'sh7fff8000, 32'sh7fff0000,
			32'sh7fffffff, 32'sh7fff0000, 32'sh7fffffff}, 0, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_MOVE, 32'sh80010000, 32'sh80020000, 32'sh80010000,
			32'sh80000000, 32'sh80000000, 32'sh80000000}, 0, '{0, 0, 0, 0, aacr_pkg::ST_OK}},
		'{'{aacr_pkg::OP_CLEAR, 0, 0, 0, 0, 0, 0}, 1, '{0, 0, 0, 0, aacr_pkg::ST_OK}}
	};

	initial begin
		motion_req_t q;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = aacr_pkg::OP_CLEAR;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		typed_now = 0;
		typed_res = '{0, 0, 0, 0, aacr_pkg::ST_OK};
		no_gaps = 0;
		error_count = 0;
		quiet_cycles = 0;
		cfg_enable = 1;
		cfg_half_w = 16384;
		cfg_half_h = 65536;
		cfg_skin = 66;
		store_count = 0;
		last_ground = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send(directed[i].req, directed[i].typed, directed[i].res);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: configure(1, 16384, 65536, 66);
				1: configure(0, $urandom_range(0, 262144), $urandom_range(0, 262144), 66);
				2: configure(1, 0, 0, 0);
				3: configure(1, 262144, 262144, 65535);
				4: configure(1, $urandom_range(0, 262144), $urandom_range(0, 262144),
					$urandom_range(0, 65535));
				default: configure(1, 16384, 65536, 66);
			endcase
			no_gaps = (ph == 4);
			for (int n = 0; n < 20; n++) begin
				if (n == 10) begin
					// hold off until the block has answered everything
					s_axis_tvalid <= 1'b0;
					@(posedge clk);
					while (pending_results.size() != 0) @(posedge clk);
				end
				q = random_item();
				send(q);
			end
			drain();
		end

		if (error_count == 0)
			$display("aabb_axis_collision_resolver_core verification clean");
		else
			$display("aabb_axis_collision_resolver_core verification failed");
		$finish;
	end

endmodule

@@ aabb_axis_collision_resolver_core.f @@
+incdir+design
design/aacr_pkg.sv
design/aacr_ram.sv
design/aacr_hit_unit.sv
design/aabb_axis_collision_resolver_core.sv
test/tb_aabb_axis_collision_resolver_core.sv
